>>> design/ufd_pkg.sv
// shared types and constants for the utf-8 stream decoder
// no dependencies
`default_nettype none

package ufd_pkg;

  localparam int CP_W       = 21;
  localparam int BYTE_W     = 8;
  localparam int BCNT_W     = 3;
  localparam int FLUSH_W    = 2;

  localparam logic [CP_W-1:0] QMARK = CP_W'(63);

  // job queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // work for the back end caused by one input word
  typedef struct packed {
    logic [FLUSH_W-1:0] flush_cnt;  // number of '?' results for held bytes
    logic               has_final;  // one more result follows the flush
    logic [CP_W-1:0]    cp;
    logic [BCNT_W-1:0]  bcnt;
    logic               rep;
  } ufd_job_t;

endpackage

`default_nettype wire

>>> design/ufd_fifo.sv
// small register queue of decode jobs
// depends on ufd_pkg
`default_nettype none

module ufd_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ufd_pkg::ufd_job_t din,
  input  wire logic            pop,
  output ufd_pkg::ufd_job_t    dout,
  output logic                 full,
  output logic                 empty
);
  import ufd_pkg::*;

  ufd_job_t              mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> design/ufd_front.sv
// front end: takes bytes, tracks the open sequence, emits decode jobs
// depends on ufd_pkg
`default_nettype none

module ufd_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic [ufd_pkg::BYTE_W-1:0]  data_byte,
  output logic                             job_push,
  output ufd_pkg::ufd_job_t                job
);
  import ufd_pkg::*;

  logic [BCNT_W-1:0]  exp_len_r, exp_len_nxt;
  logic [FLUSH_W-1:0] held_r, held_nxt;
  logic [CP_W-1:0]    partial_r, partial_nxt;

  logic              seq_open;
  logic              is_cont;
  logic [BCNT_W-1:0] held_inc;
  logic [CP_W-1:0]   partial_ext;

  assign seq_open    = (exp_len_r != '0);
  assign is_cont     = (data_byte[7:6] == 2'b10);
  assign held_inc    = {1'b0, held_r} + 1'b1;
  assign partial_ext = {partial_r[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    exp_len_nxt   = exp_len_r;
    held_nxt      = held_r;
    partial_nxt   = partial_r;
    job.flush_cnt = '0;
    job.has_final = 1'b0;
    job.cp        = QMARK;
    job.bcnt      = BCNT_W'(1);
    job.rep       = 1'b0;

    if (seq_open && is_cont) begin
      // extend the open sequence
      if (held_inc == exp_len_r) begin
        job.has_final = 1'b1;
        job.cp        = partial_ext;
        job.bcnt      = exp_len_r;
        exp_len_nxt   = '0;
        held_nxt      = '0;
        partial_nxt   = '0;
      end else begin
        held_nxt    = held_inc[FLUSH_W-1:0];
        partial_nxt = partial_ext;
      end
    end else begin
      // broken sequence flushes held bytes, then fresh decode
      job.flush_cnt = seq_open ? held_r : '0;
      exp_len_nxt   = '0;
      held_nxt      = '0;
      partial_nxt   = '0;
      if (data_byte == '0) begin
        // terminator: flush only
      end else if (!data_byte[7]) begin
        job.has_final = 1'b1;
        job.cp        = CP_W'(data_byte);
      end else if (data_byte[7:5] == 3'b110) begin
        exp_len_nxt = BCNT_W'(2);
        held_nxt    = FLUSH_W'(1);
        partial_nxt = CP_W'(data_byte[4:0]);
      end else if (data_byte[7:4] == 4'b1110) begin
        exp_len_nxt = BCNT_W'(3);
        held_nxt    = FLUSH_W'(1);
        partial_nxt = CP_W'(data_byte[3:0]);
      end else if (data_byte[7:3] == 5'b11110) begin
        exp_len_nxt = BCNT_W'(4);
        held_nxt    = FLUSH_W'(1);
        partial_nxt = CP_W'(data_byte[2:0]);
      end else begin
        // stray continuation or invalid lead
        job.has_final = 1'b1;
        job.rep       = 1'b1;
      end
    end
  end

  assign job_push = accept && (job.has_final || (job.flush_cnt != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      held_r    <= '0;
      partial_r <= '0;
    end else if (accept) begin
      exp_len_r <= exp_len_nxt;
      held_r    <= held_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ufd_back.sv
// back end: expands one job into its results, one per cycle unless out_ready stalls, into an output register
// depends on ufd_pkg
`default_nettype none

module ufd_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       head_valid,
  input  wire ufd_pkg::ufd_job_t          head,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ufd_pkg::CP_W-1:0]        out_code_point,
  output logic [ufd_pkg::BCNT_W-1:0]      out_byte_count,
  output logic                            out_replaced,
  output logic                            out_last_of_run
);
  import ufd_pkg::*;

  logic [FLUSH_W-1:0] idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]    cp_r, cp_nxt;
  logic [BCNT_W-1:0]  bcnt_r, bcnt_nxt;
  logic               rep_r, rep_nxt;
  logic               last_r, last_nxt;
  logic               load;
  logic               in_flush;
  logic               flush_last;

  assign load       = head_valid && (!out_valid_r || out_ready);
  assign in_flush   = (idx_r != head.flush_cnt);
  assign flush_last = ({1'b0, idx_r} + 1'b1 == {1'b0, head.flush_cnt}) && !head.has_final;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cp_nxt        = cp_r;
    bcnt_nxt      = bcnt_r;
    rep_nxt       = rep_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (in_flush) begin
        cp_nxt   = QMARK;
        bcnt_nxt = BCNT_W'(1);
        rep_nxt  = 1'b1;
        last_nxt = flush_last;
        if (flush_last) begin
          pop     = 1'b1;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        cp_nxt   = head.cp;
        bcnt_nxt = head.bcnt;
        rep_nxt  = head.rep;
        last_nxt = 1'b1;
        pop      = 1'b1;
        idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    bcnt_r <= bcnt_nxt;
    rep_r  <= rep_nxt;
    last_r <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_point  = cp_r;
  assign out_byte_count  = bcnt_r;
  assign out_replaced    = rep_r;
  assign out_last_of_run = last_r;

  // a partly expanded job stays at the queue head
  a_idx_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != '0) |-> head_valid)
    else $error("flush index set without a job at the head");

  // every queued job carries at least one result
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (head.has_final || (head.flush_cnt != '0)))
    else $error("empty job in queue");

  // a replaced result is always a question mark of one byte
  a_rep_qmark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rep_r) |-> (cp_r == QMARK && bcnt_r == BCNT_W'(1)))
    else $error("replaced result with wrong payload");

  // the job leaves the queue only with its last result
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && last_r))
    else $error("job popped without a last result");

endmodule

`default_nettype wire

>>> design/utf8_stream_decoder.sv
// utf-8 stream decoder: one byte word in, decoded code points out
// path: an accepted byte's job is written into the job queue, then its first result into the output register
// throughput: one byte per cycle unless the job queue is full; a byte that breaks a
//   sequence gives up to 4 results, one per unstalled cycle, via the single-result output register
// reset: synchronous active-low rst_n closes any open sequence and empties the queue
// depends on ufd_pkg, ufd_front, ufd_fifo, ufd_back
`default_nettype none

module utf8_stream_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // byte word input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ufd_pkg::BYTE_W-1:0] in_data_byte,
  // result word output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [ufd_pkg::CP_W-1:0]        out_code_point,
  output logic [ufd_pkg::BCNT_W-1:0]      out_byte_count,
  output logic                            out_replaced,
  output logic                            out_last_of_run
);
  import ufd_pkg::*;

  logic     accept;
  logic     job_push;
  ufd_job_t job;
  ufd_job_t head;
  logic     q_full;
  logic     q_empty;
  logic     pop;

  // the front only stalls when the job queue is full
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // front: sequence tracking and byte classification
  ufd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .job_push  (job_push),
    .job       (job)
  );

  // short queue decouples byte intake from result expansion
  ufd_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: one result per cycle, unless out_ready stalls, into the output register
  ufd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (!q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_point  (out_code_point),
    .out_byte_count  (out_byte_count),
    .out_replaced    (out_replaced),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
